FILE: sv/ledtmr_pkg.sv
// ----------------------------------------------------------------------------
// ledtmr_pkg
// Shared types, sizes and command codes of the activity LED timer controller.
// ----------------------------------------------------------------------------
package ledtmr_pkg;

   localparam int NUM_LEDS       = 6;
   localparam int COUNT_BITS     = 16;
   localparam int ACTION_BITS    = 3;
   localparam int INDEX_BITS     = 3;
   localparam int AMOUNT_BITS    = 16;
   localparam int MASK_BITS      = 6;
   localparam int TICKS_BITS     = 16;
   localparam int CSR_INDEX_BITS = 1;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 8;

   localparam logic [TICKS_BITS-1:0] FLASH_TICKS_RESET = TICKS_BITS'(100);

   // Command codes.
   localparam logic [ACTION_BITS-1:0] ACT_ACTIVITY = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_SET_ON   = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SET_OFF  = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_ALL_ON   = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_ALL_OFF  = 3'd4;
   localparam logic [ACTION_BITS-1:0] ACT_FLASH    = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_TICK     = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLASH_ON  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FLASH_OFF = 1'd1;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [TICKS_BITS-1:0] ticks_type;
   typedef logic [NUM_LEDS-1:0]   leds_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [INDEX_BITS-1:0]  led_index;
      logic [AMOUNT_BITS-1:0] amount;
   } command_type;

   // Per-LED update result handed to the flash sequencer.
   typedef struct packed {
      logic     want;
      leds_type on_next;
   } led_status_type;

   typedef struct packed {
      leds_type shown;
      logic     draw;
      logic     flashing;
   } flash_result_type;

endpackage

FILE: sv/ledtmr_leds.sv
// ----------------------------------------------------------------------------
// ledtmr_leds
// On bits and auto-off countdowns of all LEDs, updated in parallel per word.
// ----------------------------------------------------------------------------
module ledtmr_leds (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  ledtmr_pkg::command_type     cmd,
   output ledtmr_pkg::led_status_type  status
);

   ledtmr_pkg::leds_type  led_on_ff;
   ledtmr_pkg::leds_type  led_on_in;
   ledtmr_pkg::count_type countdown_ff [ledtmr_pkg::NUM_LEDS];
   ledtmr_pkg::count_type countdown_in [ledtmr_pkg::NUM_LEDS];
   ledtmr_pkg::leds_type  sel;
   ledtmr_pkg::leds_type  expired;

   for (genvar i = 0; i < ledtmr_pkg::NUM_LEDS; i++) begin : g_led
      assign sel[i] = (32'(cmd.led_index) == i);

      always_comb begin
         led_on_in[i]    = led_on_ff[i];
         countdown_in[i] = countdown_ff[i];
         expired[i]      = 1'b0;
         case (cmd.action)
            ledtmr_pkg::ACT_ACTIVITY, ledtmr_pkg::ACT_SET_ON,
            ledtmr_pkg::ACT_SET_OFF: begin
               if (sel[i]) begin
                  led_on_in[i]    = (cmd.action != ledtmr_pkg::ACT_SET_OFF);
                  countdown_in[i] = (cmd.action == ledtmr_pkg::ACT_ACTIVITY) ?
                                    ledtmr_pkg::count_type'(cmd.amount) : '0;
               end
            end
            ledtmr_pkg::ACT_ALL_ON: begin
               led_on_in[i]    = 1'b1;
               countdown_in[i] = '0;
            end
            ledtmr_pkg::ACT_ALL_OFF: begin
               led_on_in[i]    = 1'b0;
               countdown_in[i] = '0;
            end
            ledtmr_pkg::ACT_TICK: begin
               if (countdown_ff[i] != '0) begin
                  countdown_in[i] = countdown_ff[i] - 1'b1;
                  if (countdown_ff[i] == ledtmr_pkg::count_type'(1)) begin
                     led_on_in[i] = 1'b0;
                     expired[i]   = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            led_on_ff[i]    <= 1'b0;
            countdown_ff[i] <= '0;
         end else if (fire) begin
            led_on_ff[i]    <= led_on_in[i];
            countdown_ff[i] <= countdown_in[i];
         end
      end
   end

   // A single-LED command only counts when its index names an existing LED.
   always_comb begin
      status.on_next = led_on_in;
      case (cmd.action)
         ledtmr_pkg::ACT_ACTIVITY, ledtmr_pkg::ACT_SET_ON,
         ledtmr_pkg::ACT_SET_OFF:  status.want = |sel;
         ledtmr_pkg::ACT_ALL_ON,
         ledtmr_pkg::ACT_ALL_OFF:  status.want = 1'b1;
         ledtmr_pkg::ACT_TICK:     status.want = |expired;
         default:                  status.want = 1'b0;
      endcase
   end

endmodule

FILE: sv/ledtmr_flash.sv
// ----------------------------------------------------------------------------
// ledtmr_flash
// Flash-all sequencer and the displayed mask.
// ----------------------------------------------------------------------------
module ledtmr_flash (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  ledtmr_pkg::command_type       cmd,
   input  ledtmr_pkg::led_status_type    status,
   input  ledtmr_pkg::ticks_type         flash_on_ticks,
   input  ledtmr_pkg::ticks_type         flash_off_ticks,
   output ledtmr_pkg::flash_result_type  result
);

   logic [ledtmr_pkg::AMOUNT_BITS-1:0] flashes_ff;
   logic [ledtmr_pkg::AMOUNT_BITS-1:0] flashes_in;
   logic [ledtmr_pkg::AMOUNT_BITS-1:0] flashes_dec;
   ledtmr_pkg::ticks_type              phase_ff;
   ledtmr_pkg::ticks_type              phase_in;
   logic                               lit_ff;
   logic                               lit_in;
   ledtmr_pkg::leds_type               shown_ff;
   ledtmr_pkg::leds_type               shown_in;
   logic                               draw;
   logic                               was_flashing;

   assign was_flashing = (flashes_ff != '0);
   assign flashes_dec  = flashes_ff - 1'b1;

   always_comb begin
      flashes_in = flashes_ff;
      phase_in   = phase_ff;
      lit_in     = lit_ff;
      shown_in   = shown_ff;
      draw       = 1'b0;
      case (cmd.action)
         ledtmr_pkg::ACT_FLASH: begin
            if (!was_flashing && cmd.amount != '0) begin
               flashes_in = cmd.amount;
               lit_in     = 1'b1;
               phase_in   = flash_on_ticks;
               shown_in   = '1;
               draw       = 1'b1;
            end
         end
         ledtmr_pkg::ACT_TICK: begin
            if (was_flashing) begin
               // A phase count of zero behaves as one and ends the phase now.
               if (phase_ff > ledtmr_pkg::ticks_type'(1)) begin
                  phase_in = phase_ff - 1'b1;
               end else if (lit_ff) begin
                  flashes_in = flashes_dec;
                  shown_in   = '0;
                  draw       = 1'b1;
                  lit_in     = 1'b0;
                  phase_in   = (flashes_dec != '0) ? flash_off_ticks : '0;
               end else begin
                  lit_in   = 1'b1;
                  phase_in = flash_on_ticks;
                  shown_in = '1;
                  draw     = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      if (status.want && !was_flashing) begin
         shown_in = status.on_next;
         draw     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flashes_ff <= '0;
         phase_ff   <= '0;
         lit_ff     <= 1'b0;
         shown_ff   <= '0;
      end else if (fire) begin
         flashes_ff <= flashes_in;
         phase_ff   <= phase_in;
         lit_ff     <= lit_in;
         shown_ff   <= shown_in;
      end
   end

   assign result.shown    = shown_in;
   assign result.draw     = draw;
   assign result.flashing = (flashes_in != '0);

endmodule

FILE: sv/activity_led_timer_controller.sv
// ----------------------------------------------------------------------------
// activity_led_timer_controller
// Six status LEDs with auto-off countdowns and a flash-all sequence.
// ----------------------------------------------------------------------------
// Each command or millisecond tick word produces exactly one response word
// carrying the displayed mask, a refresh flag and the flashing flag. The block
// takes one word per clock: a word is registered, updated against the LED and
// flash state, and its response is registered in the output register. All
// countdowns decrement in parallel on a tick, so the rate is one word per
// cycle as long as the response side keeps up. Configuration writes to the
// flash phase lengths are taken in any cycle.
module activity_led_timer_controller (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // action [2:0]
   input  logic [ledtmr_pkg::ACTION_BITS-1:0]        req_tuser,
   // led_index [2:0], amount [18:3], zero [23:19]
   input  logic [ledtmr_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // led_mask [5:0], refresh [6], flashing [7]
   output logic [ledtmr_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [ledtmr_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [ledtmr_pkg::TICKS_BITS-1:0]         csr_data
);

   logic                             in_valid_ff;
   ledtmr_pkg::command_type          in_cmd_ff;
   logic                             advance;
   logic                             fire;
   logic                             rsp_valid_ff;
   logic [ledtmr_pkg::MASK_BITS-1:0] rsp_mask_ff;
   logic                             rsp_refresh_ff;
   logic                             rsp_flashing_ff;
   ledtmr_pkg::ticks_type            flash_on_ff;
   ledtmr_pkg::ticks_type            flash_off_ff;
   ledtmr_pkg::led_status_type       led_status;
   ledtmr_pkg::flash_result_type     flash_result;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_cmd_ff.action    <= req_tuser;
         in_cmd_ff.led_index <= req_tdata[2:0];
         in_cmd_ff.amount    <= req_tdata[18:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flash_on_ff  <= ledtmr_pkg::FLASH_TICKS_RESET;
         flash_off_ff <= ledtmr_pkg::FLASH_TICKS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ledtmr_pkg::CSR_FLASH_ON:  flash_on_ff  <= csr_data;
            ledtmr_pkg::CSR_FLASH_OFF: flash_off_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ledtmr_leds u_leds (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cmd    (in_cmd_ff),
      .status (led_status)
   );

   ledtmr_flash u_flash (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .cmd             (in_cmd_ff),
      .status          (led_status),
      .flash_on_ticks  (flash_on_ff),
      .flash_off_ticks (flash_off_ff),
      .result          (flash_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_mask_ff     <= ledtmr_pkg::MASK_BITS'(flash_result.shown);
         rsp_refresh_ff  <= flash_result.draw;
         rsp_flashing_ff <= flash_result.flashing;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_flashing_ff, rsp_refresh_ff, rsp_mask_ff};

endmodule

FILE: bench/tb_activity_led_timer_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_activity_led_timer_controller
// Self-checking bench for the activity LED timer controller.
// ----------------------------------------------------------------------------
// Command and tick words are streamed into the block with random gaps while
// the response side stalls at random. A tracker class keeps its own copy of
// the LED, countdown and flash state, predicts the response word of every
// accepted command and compares each returned word against the oldest
// prediction. A short directed sequence opens the run, followed by random
// traffic under several flash phase settings, a full flash sweep with zero
// phase lengths and a last random stretch at the longest phase lengths.
module tb_activity_led_timer_controller;

   localparam logic [ledtmr_pkg::ACTION_BITS-1:0] ACT_UNDEFINED = 3'd7;
   localparam int DRAIN_CYCLES = 4;

   typedef struct packed {
      ledtmr_pkg::leds_type led_mask;
      logic                 refresh;
      logic                 flashing;
   } display_word_type;

   class led_display_tracker;
      ledtmr_pkg::leds_type  led_on;
      ledtmr_pkg::count_type countdown [ledtmr_pkg::NUM_LEDS];
      logic [15:0]           flashes_left;
      ledtmr_pkg::ticks_type phase_left;
      bit                    lit_phase;
      ledtmr_pkg::leds_type  shown;
      ledtmr_pkg::ticks_type on_ticks;
      ledtmr_pkg::ticks_type off_ticks;
      display_word_type      expected_words [$];
      int                    mismatches;

      function new();
         led_on = '0;
         foreach (countdown[i]) countdown[i] = '0;
         flashes_left = '0;
         phase_left = '0;
         lit_phase = 1'b0;
         shown = '0;
         on_ticks = ledtmr_pkg::FLASH_TICKS_RESET;
         off_ticks = ledtmr_pkg::FLASH_TICKS_RESET;
         mismatches = 0;
      endfunction

      function void set_register(logic [ledtmr_pkg::CSR_INDEX_BITS-1:0] index,
                                 ledtmr_pkg::ticks_type value);
         if (index == ledtmr_pkg::CSR_FLASH_ON) begin
            on_ticks = value;
         end else begin
            off_ticks = value;
         end
      endfunction

      function bit flashing();
         return flashes_left != 0;
      endfunction

      function void note_command(ledtmr_pkg::command_type cmd);
         display_word_type word;
         bit want;
         bit draw;
         bit was_flashing;
         want = 1'b0;
         draw = 1'b0;
         was_flashing = (flashes_left != 0);
         case (cmd.action)
            ledtmr_pkg::ACT_ACTIVITY, ledtmr_pkg::ACT_SET_ON,
            ledtmr_pkg::ACT_SET_OFF: begin
               if (cmd.led_index < ledtmr_pkg::NUM_LEDS) begin
                  led_on[cmd.led_index] = (cmd.action != ledtmr_pkg::ACT_SET_OFF);
                  countdown[cmd.led_index] =
                     (cmd.action == ledtmr_pkg::ACT_ACTIVITY) ? cmd.amount : '0;
                  want = 1'b1;
               end
            end
            ledtmr_pkg::ACT_ALL_ON, ledtmr_pkg::ACT_ALL_OFF: begin
               led_on = (cmd.action == ledtmr_pkg::ACT_ALL_ON) ? '1 : '0;
               foreach (countdown[i]) countdown[i] = '0;
               want = 1'b1;
            end
            ledtmr_pkg::ACT_FLASH: begin
               if (!was_flashing && cmd.amount != 0) begin
                  flashes_left = cmd.amount;
                  lit_phase = 1'b1;
                  phase_left = on_ticks;
                  shown = '1;
                  draw = 1'b1;
               end
            end
            ledtmr_pkg::ACT_TICK: begin
               foreach (countdown[i]) begin
                  if (countdown[i] != 0) begin
                     countdown[i] = countdown[i] - 1'b1;
                     if (countdown[i] == 0) begin
                        led_on[i] = 1'b0;
                        want = 1'b1;
                     end
                  end
               end
               // A phase length of zero behaves like one tick.
               if (was_flashing) begin
                  if (phase_left > 1) begin
                     phase_left = phase_left - 1'b1;
                  end else if (lit_phase) begin
                     flashes_left = flashes_left - 1'b1;
                     shown = '0;
                     draw = 1'b1;
                     lit_phase = 1'b0;
                     phase_left = (flashes_left != 0) ? off_ticks : '0;
                  end else begin
                     lit_phase = 1'b1;
                     phase_left = on_ticks;
                     shown = '1;
                     draw = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
         if (want && !was_flashing) begin
            shown = led_on;
            draw = 1'b1;
         end
         word.led_mask = shown;
         word.refresh = draw;
         word.flashing = (flashes_left != 0);
         expected_words.push_back(word);
      endfunction

      function void check_word(logic [ledtmr_pkg::RSP_DATA_BITS-1:0] data);
         display_word_type want_word;
         if (expected_words.size() == 0) begin
            $error("response word 0x%02h arrived with nothing outstanding", data);
            mismatches++;
            return;
         end
         want_word = expected_words.pop_front();
         if (data[5:0] !== want_word.led_mask) begin
            $error("led_mask: expected 0x%02h, got 0x%02h", want_word.led_mask, data[5:0]);
            mismatches++;
         end
         if (data[6] !== want_word.refresh) begin
            $error("refresh: expected %0b, got %0b", want_word.refresh, data[6]);
            mismatches++;
         end
         if (data[7] !== want_word.flashing) begin
            $error("flashing: expected %0b, got %0b", want_word.flashing, data[7]);
            mismatches++;
         end
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [ledtmr_pkg::ACTION_BITS-1:0]    req_tuser;
   logic [ledtmr_pkg::REQ_DATA_BITS-1:0]  req_tdata;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [ledtmr_pkg::RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                                  csr_valid;
   logic                                  csr_ready;
   logic [ledtmr_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [ledtmr_pkg::TICKS_BITS-1:0]     csr_data;

   led_display_tracker tracker = new();
   bit send_quiet;
   bit recv_quiet;

   activity_led_timer_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one; none in quiet stretches.
   function automatic int pick_gap(bit quiet);
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0) recv_quiet = ~recv_quiet;
         stall = pick_gap(recv_quiet);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) tracker.check_word(rsp_tdata);
   end

   task automatic send_command(logic [ledtmr_pkg::ACTION_BITS-1:0] action,
                               logic [ledtmr_pkg::INDEX_BITS-1:0] led_index,
                               logic [ledtmr_pkg::AMOUNT_BITS-1:0] amount);
      ledtmr_pkg::command_type cmd;
      int gap;
      cmd.action = action;
      cmd.led_index = led_index;
      cmd.amount = amount;
      gap = pick_gap(send_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= {5'b00000, amount, led_index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.note_command(cmd);
   endtask

   // Holds the sender off until every outstanding response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [ledtmr_pkg::CSR_INDEX_BITS-1:0] index,
                                 ledtmr_pkg::ticks_type value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tracker.set_register(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_flash_phases(ledtmr_pkg::ticks_type on_len,
                                   ledtmr_pkg::ticks_type off_len);
      drain_responses();
      write_register(ledtmr_pkg::CSR_FLASH_ON, on_len);
      write_register(ledtmr_pkg::CSR_FLASH_OFF, off_len);
   endtask

   task automatic send_random_command(int flash_max);
      int sel;
      logic [ledtmr_pkg::ACTION_BITS-1:0] action;
      logic [ledtmr_pkg::INDEX_BITS-1:0] led_index;
      logic [ledtmr_pkg::AMOUNT_BITS-1:0] amount;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) begin
         led_index = ledtmr_pkg::INDEX_BITS'($urandom_range(6, 7));
      end else begin
         led_index = ledtmr_pkg::INDEX_BITS'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 3))
         0: amount = ledtmr_pkg::AMOUNT_BITS'($urandom_range(0, 3));
         1: amount = ledtmr_pkg::AMOUNT_BITS'($urandom_range(1, 40));
         2: amount = ledtmr_pkg::AMOUNT_BITS'($urandom);
         default: amount = ledtmr_pkg::AMOUNT_BITS'($urandom_range(0, 12));
      endcase
      if (sel < 40) begin
         action = ledtmr_pkg::ACT_TICK;
      end else if (sel < 62) begin
         action = ledtmr_pkg::ACT_ACTIVITY;
      end else if (sel < 70) begin
         action = ledtmr_pkg::ACT_SET_ON;
      end else if (sel < 77) begin
         action = ledtmr_pkg::ACT_SET_OFF;
      end else if (sel < 81) begin
         action = ledtmr_pkg::ACT_ALL_ON;
      end else if (sel < 85) begin
         action = ledtmr_pkg::ACT_ALL_OFF;
      end else if (sel < 95) begin
         action = ledtmr_pkg::ACT_FLASH;
         amount = ledtmr_pkg::AMOUNT_BITS'($urandom_range(0, flash_max));
      end else begin
         action = ACT_UNDEFINED;
      end
      send_command(action, led_index, amount);
   endtask

   task automatic run_random(int count, int flash_max);
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 99) == 0) drain_responses();
         send_random_command(flash_max);
      end
   endtask

   // One flash at a given count, carried to its end by ticks with a few
   // unrelated commands mixed in.
   task automatic sweep_flash(logic [ledtmr_pkg::AMOUNT_BITS-1:0] count);
      while (tracker.flashing()) send_command(ledtmr_pkg::ACT_TICK, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_FLASH, 3'd0, count);
      while (tracker.flashing()) begin
         if ($urandom_range(0, 9) == 0) begin
            send_random_command(0);
         end else begin
            send_command(ledtmr_pkg::ACT_TICK, ledtmr_pkg::INDEX_BITS'($urandom),
                         ledtmr_pkg::AMOUNT_BITS'($urandom));
         end
      end
   endtask

   initial begin
      int leftover;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= '0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(ledtmr_pkg::ACT_TICK, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_ACTIVITY, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_ACTIVITY, 3'd5, 16'hFFFF);
      send_command(ledtmr_pkg::ACT_ACTIVITY, 3'd1, 16'd1);
      send_command(ledtmr_pkg::ACT_TICK, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_ACTIVITY, 3'd6, 16'd5);
      send_command(ledtmr_pkg::ACT_SET_ON, 3'd7, 16'd0);
      send_command(ledtmr_pkg::ACT_SET_ON, 3'd2, 16'd0);
      send_command(ledtmr_pkg::ACT_SET_OFF, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_ALL_ON, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_ALL_OFF, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_FLASH, 3'd0, 16'd0);
      send_command(ACT_UNDEFINED, 3'd3, 16'hFFFF);
      send_command(ledtmr_pkg::ACT_SET_ON, 3'd3, 16'd0);

      // Short phases so a whole two-flash sequence fits in a few ticks; the
      // countdown on LED 4 runs out while the flash is dark.
      set_flash_phases(16'd2, 16'd1);
      send_command(ledtmr_pkg::ACT_ACTIVITY, 3'd4, 16'd3);
      send_command(ledtmr_pkg::ACT_FLASH, 3'd0, 16'd2);
      send_command(ledtmr_pkg::ACT_FLASH, 3'd0, 16'd3);
      send_command(ledtmr_pkg::ACT_SET_OFF, 3'd3, 16'd0);
      repeat (5) send_command(ledtmr_pkg::ACT_TICK, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_TICK, 3'd0, 16'd0);
      send_command(ledtmr_pkg::ACT_SET_ON, 3'd0, 16'd0);

      set_flash_phases(16'd1, 16'd1);
      run_random(160, 4);
      set_flash_phases(16'd3, 16'd2);
      run_random(160, 3);
      set_flash_phases(16'd2, 16'd7);
      run_random(160, 3);
      set_flash_phases(16'd4, 16'd1);
      run_random(160, 4);

      send_quiet = 1'b0;
      set_flash_phases(16'd0, 16'd0);
      sweep_flash(16'd3);
      set_flash_phases(16'hFFFF, 16'hFFFF);
      run_random(40, 2);

      drain_responses();
      repeat (10) @(posedge clock);
      leftover = tracker.expected_words.size();
      if (leftover != 0) $error("%0d response words never arrived", leftover);
      if (tracker.mismatches == 0 && leftover == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
